FILE: rtl/core/stok_pkg.sv
// Shared constants, token kinds and character classification for the source tokenizer.
package stok_pkg;

    localparam int OFFSET_BITS_DEF     = 24;
    localparam int POSITION_BITS_DEF   = 16;
    localparam int KEYWORD_MAX_LEN_DEF = 5;
    localparam int KIND_BITS           = 6;
    localparam int LEN_BITS            = 16;
    localparam int KEYWORD_COUNT       = 10;
    localparam int KW_BUF_MAX          = 64;

    localparam logic [KIND_BITS-1:0] KIND_STRING = 6'd29;
    localparam logic [KIND_BITS-1:0] KIND_INT    = 6'd30;
    localparam logic [KIND_BITS-1:0] KIND_IDENT  = 6'd40;
    localparam logic [KIND_BITS-1:0] KIND_END    = 6'd41;
    localparam logic [KIND_BITS-1:0] KIND_ERROR  = 6'd42;

    typedef struct packed {
        logic                 ok;
        logic [KIND_BITS-1:0] kind;
    } kind_hit_t;

    localparam logic [39:0] KW_TEXT [KEYWORD_COUNT] = '{
        40'h66616c7365, 40'h0074727565, 40'h0000006966, 40'h00656c7365,
        40'h00656c6966, 40'h7768696c65, 40'h0000666f72, 40'h007468656e,
        40'h627265616b, 40'h0074797065};
    localparam logic [2:0] KW_LEN [KEYWORD_COUNT] = '{
        3'd5, 3'd4, 3'd2, 3'd4, 3'd4, 3'd5, 3'd3, 3'd4, 3'd5, 3'd4};
    localparam logic [KIND_BITS-1:0] KW_KIND [KEYWORD_COUNT] = '{
        6'd31, 6'd31, 6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38, 6'd39};

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic may_pair(input logic [7:0] c);
        return c == "+" || c == "-" || c == "*" || c == "/" || c == ":" ||
               c == "(" || c == "." || c == "!" || c == "=";
    endfunction

    function automatic kind_hit_t single_kind(input logic [7:0] c);
        kind_hit_t r;
        r.ok = 1'b1;
        unique case (c)
            "+": r.kind = 6'd0;
            "-": r.kind = 6'd2;
            "*": r.kind = 6'd5;
            "/": r.kind = 6'd7;
            ";": r.kind = 6'd9;
            ":": r.kind = 6'd10;
            ",": r.kind = 6'd12;
            "(": r.kind = 6'd13;
            ")": r.kind = 6'd15;
            "{": r.kind = 6'd16;
            "}": r.kind = 6'd17;
            "[": r.kind = 6'd18;
            "]": r.kind = 6'd19;
            ".": r.kind = 6'd20;
            "!": r.kind = 6'd22;
            "%": r.kind = 6'd24;
            "_": r.kind = 6'd25;
            "|": r.kind = 6'd26;
            "=": r.kind = 6'd27;
            default: begin
                r.ok   = 1'b0;
                r.kind = KIND_ERROR;
            end
        endcase
        return r;
    endfunction

    function automatic kind_hit_t pair_kind(input logic [7:0] a, input logic [7:0] b);
        kind_hit_t r;
        r.ok   = 1'b1;
        r.kind = KIND_ERROR;
        priority if (b == "=" && a == "+") r.kind = 6'd1;
        else if (b == "=" && a == "-") r.kind = 6'd3;
        else if (b == "=" && a == "*") r.kind = 6'd6;
        else if (b == "=" && a == "/") r.kind = 6'd8;
        else if (b == "=" && a == "!") r.kind = 6'd23;
        else if (b == "=" && a == "=") r.kind = 6'd28;
        else if (a == "-" && b == ">") r.kind = 6'd4;
        else if (a == ":" && b == ":") r.kind = 6'd11;
        else if (a == "(" && b == ")") r.kind = 6'd14;
        else if (a == "." && b == ".") r.kind = 6'd21;
        else r.ok = 1'b0;
        return r;
    endfunction

    function automatic logic [KIND_BITS-1:0] ident_kind(input logic [KW_BUF_MAX-1:0] buf_in,
                                                         input logic [LEN_BITS-1:0] len);
        logic [KIND_BITS-1:0] k;
        k = KIND_IDENT;
        for (int i = 0; i < KEYWORD_COUNT; i++) begin
            if (len == LEN_BITS'(KW_LEN[i]) && buf_in == KW_BUF_MAX'(KW_TEXT[i])) begin
                k = KW_KIND[i];
            end
        end
        return k;
    endfunction

endpackage

FILE: rtl/core/stok_scan.sv
// Scanner state registers and the combinational next-state and token logic.
module stok_scan #(
    parameter int OFFSET_BITS     = stok_pkg::OFFSET_BITS_DEF,
    parameter int POSITION_BITS   = stok_pkg::POSITION_BITS_DEF,
    parameter int KEYWORD_MAX_LEN = stok_pkg::KEYWORD_MAX_LEN_DEF,
    parameter int RW = stok_pkg::KIND_BITS + OFFSET_BITS + 2 * POSITION_BITS
                       + stok_pkg::LEN_BITS + 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              take,
    input  logic [7:0]        source_byte,
    input  logic              end_of_source,
    output logic [1:0]        push_count,
    output logic [3*RW-1:0]   push_data
);

    localparam int OB = OFFSET_BITS;
    localparam int PB = POSITION_BITS;
    localparam int LB = stok_pkg::LEN_BITS;
    localparam int KB = 8 * KEYWORD_MAX_LEN;
    localparam logic [PB-1:0] POS_MAX = {PB{1'b1}};
    localparam logic [LB-1:0] LEN_MAX = {LB{1'b1}};

    localparam logic [2:0] MODE_IDLE = 3'd0;
    localparam logic [2:0] MODE_OP   = 3'd1;
    localparam logic [2:0] MODE_ID   = 3'd2;
    localparam logic [2:0] MODE_INT  = 3'd3;
    localparam logic [2:0] MODE_FRAC = 3'd4;
    localparam logic [2:0] MODE_STR  = 3'd5;

    logic [2:0]    mode_reg,  mode_next;
    logic [7:0]    pend_reg,  pend_next;
    logic [OB-1:0] off_reg,   off_next;
    logic [PB-1:0] row_reg,   row_next;
    logic [PB-1:0] col_reg,   col_next;
    logic [OB-1:0] soff_reg,  soff_next;
    logic [PB-1:0] srow_reg,  srow_next;
    logic [PB-1:0] scol_reg,  scol_next;
    logic [LB-1:0] len_reg,   len_next;
    logic [KB-1:0] kbuf_reg,  kbuf_next;
    logic          halt_reg,  halt_next;

    logic [RW-1:0] res [3];
    logic [1:0]    n;

    function automatic logic [PB-1:0] pos_add(input logic [PB-1:0] v, input logic [2:0] a);
        logic [PB:0] s;
        s = {1'b0, v} + (PB + 1)'(a);
        return s[PB] ? POS_MAX : s[PB-1:0];
    endfunction

    function automatic logic [RW-1:0] pack(input logic [stok_pkg::KIND_BITS-1:0] k,
                                           input logic [OB-1:0] o, input logic [PB-1:0] r,
                                           input logic [PB-1:0] c, input logic [LB-1:0] l);
        return {1'b0, l, c, r, o, k};
    endfunction

    always_comb begin
        logic [7:0]  c;
        logic        fl;
        logic        go;
        stok_pkg::kind_hit_t pk;
        stok_pkg::kind_hit_t sk;
        c  = source_byte;
        fl = 1'b0;
        go = 1'b1;
        mode_next = mode_reg;  pend_next = pend_reg;  off_next = off_reg;
        row_next  = row_reg;   col_next  = col_reg;   soff_next = soff_reg;
        srow_next = srow_reg;  scol_next = scol_reg;  len_next  = len_reg;
        kbuf_next = kbuf_reg;  halt_next = halt_reg;
        n = 2'd0;
        res[0] = '0; res[1] = '0; res[2] = '0;
        pk = stok_pkg::pair_kind(pend_reg, c);
        sk = stok_pkg::single_kind(c);

        if (!halt_reg && c != 8'd0) begin
            unique case (mode_reg)
                MODE_OP: begin
                    if (pk.ok) begin
                        res[n] = pack(pk.kind, soff_reg, srow_reg, scol_reg, LB'(2));
                        n = n + 2'd1;
                        off_next = off_reg + 1'b1;
                        col_next = pos_add(col_reg, 3'd1);
                        mode_next = MODE_IDLE;
                        go = 1'b0;
                    end else begin
                        fl = 1'b1;
                    end
                end
                MODE_ID: begin
                    if (stok_pkg::is_letter(c)) begin
                        if (len_reg < LB'(KEYWORD_MAX_LEN)) kbuf_next = {kbuf_reg[KB-9:0], c};
                        if (len_reg != LEN_MAX) len_next = len_reg + 1'b1;
                        off_next = off_reg + 1'b1;
                        col_next = pos_add(col_reg, 3'd1);
                        go = 1'b0;
                    end else begin
                        fl = 1'b1;
                    end
                end
                MODE_INT, MODE_FRAC: begin
                    if (stok_pkg::is_digit(c) || (mode_reg == MODE_INT && c == ".")) begin
                        if (c == ".") mode_next = MODE_FRAC;
                        if (len_reg != LEN_MAX) len_next = len_reg + 1'b1;
                        off_next = off_reg + 1'b1;
                        col_next = pos_add(col_reg, 3'd1);
                        go = 1'b0;
                    end else begin
                        fl = 1'b1;
                    end
                end
                MODE_STR: begin
                    if (c == "\"") begin
                        res[n] = pack(stok_pkg::KIND_STRING, soff_reg, srow_reg, scol_reg,
                                      len_reg);
                        n = n + 2'd1;
                        mode_next = MODE_IDLE;
                    end else if (len_reg != LEN_MAX) begin
                        len_next = len_reg + 1'b1;
                    end
                    off_next = off_reg + 1'b1;
                    col_next = pos_add(col_reg, 3'd1);
                    go = 1'b0;
                end
                default: begin
                    mode_next = MODE_IDLE;
                end
            endcase

            if (fl) begin
                unique case (mode_reg)
                    MODE_OP: res[n] = pack(stok_pkg::single_kind(pend_reg).kind, soff_reg,
                                           srow_reg, scol_reg, len_reg);
                    MODE_ID: res[n] = pack(stok_pkg::ident_kind(
                                           stok_pkg::KW_BUF_MAX'(kbuf_reg), len_reg),
                                           soff_reg, srow_reg, scol_reg, len_reg);
                    default: res[n] = pack(stok_pkg::KIND_INT, soff_reg, srow_reg, scol_reg,
                                           len_reg);
                endcase
                n = n + 2'd1;
                mode_next = MODE_IDLE;
            end

            if (go) begin
                priority if (c == 8'h0d || c == 8'h0a) begin
                    row_next = pos_add(row_reg, 3'd1);
                    col_next = PB'(1);
                    off_next = off_reg + 1'b1;
                end else if (c == 8'h09) begin
                    col_next = pos_add(col_reg, 3'd4);
                    off_next = off_reg + 1'b1;
                end else if (c == " ") begin
                    col_next = pos_add(col_reg, 3'd1);
                    off_next = off_reg + 1'b1;
                end else if (c == "\"" || stok_pkg::is_digit(c) || stok_pkg::is_letter(c)
                             || stok_pkg::may_pair(c) || sk.ok) begin
                    soff_next = off_reg;
                    srow_next = row_reg;
                    scol_next = col_reg;
                    len_next  = LB'(1);
                    kbuf_next = '0;
                    off_next  = off_reg + 1'b1;
                    col_next  = pos_add(col_reg, 3'd1);
                    priority if (c == "\"") begin
                        len_next  = '0;
                        mode_next = MODE_STR;
                    end else if (stok_pkg::is_digit(c)) begin
                        mode_next = MODE_INT;
                    end else if (stok_pkg::is_letter(c)) begin
                        kbuf_next = KB'(c);
                        mode_next = MODE_ID;
                    end else if (stok_pkg::may_pair(c)) begin
                        pend_next = c;
                        mode_next = MODE_OP;
                    end else begin
                        res[n] = pack(sk.kind, off_reg, row_reg, col_reg, LB'(1));
                        n = n + 2'd1;
                    end
                end else begin
                    res[n] = pack(stok_pkg::KIND_ERROR, off_reg, row_reg, col_reg, LB'(1));
                    n = n + 2'd1;
                    halt_next = 1'b1;
                end
            end
        end

        if (!halt_reg && !halt_next && (c == 8'd0 || end_of_source)) begin
            unique case (mode_next)
                MODE_OP: begin
                    res[n] = pack(stok_pkg::single_kind(pend_next).kind, soff_next, srow_next,
                                  scol_next, len_next);
                    n = n + 2'd1;
                end
                MODE_ID: begin
                    res[n] = pack(stok_pkg::ident_kind(stok_pkg::KW_BUF_MAX'(kbuf_next),
                                  len_next), soff_next, srow_next, scol_next, len_next);
                    n = n + 2'd1;
                end
                MODE_INT, MODE_FRAC: begin
                    res[n] = pack(stok_pkg::KIND_INT, soff_next, srow_next, scol_next,
                                  len_next);
                    n = n + 2'd1;
                end
                MODE_STR: begin
                    res[n] = pack(stok_pkg::KIND_STRING, soff_next, srow_next, scol_next,
                                  len_next);
                    n = n + 2'd1;
                end
                default: begin
                end
            endcase
            mode_next = MODE_IDLE;
            res[n] = pack(stok_pkg::KIND_END, off_next, row_next, col_next, '0);
            n = n + 2'd1;
            halt_next = 1'b1;
        end

        if (n != 2'd0) res[n - 2'd1][RW-1] = 1'b1;
    end

    assign push_count = take ? n : 2'd0;
    assign push_data  = {res[2], res[1], res[0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            pend_reg <= '0;
            off_reg  <= '0;
            row_reg  <= PB'(1);
            col_reg  <= PB'(1);
            soff_reg <= '0;
            srow_reg <= PB'(1);
            scol_reg <= PB'(1);
            len_reg  <= '0;
            kbuf_reg <= '0;
            halt_reg <= 1'b0;
        end else if (take) begin
            mode_reg <= mode_next;
            pend_reg <= pend_next;
            off_reg  <= off_next;
            row_reg  <= row_next;
            col_reg  <= col_next;
            soff_reg <= soff_next;
            srow_reg <= srow_next;
            scol_reg <= scol_next;
            len_reg  <= len_next;
            kbuf_reg <= kbuf_next;
            halt_reg <= halt_next;
        end
    end

endmodule

FILE: rtl/core/stok_fifo.sv
// Four-entry token queue that takes up to three tokens a cycle and gives one while popped.
module stok_fifo #(
    parameter int RW = 80
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic [1:0]      push_count,
    input  logic [3*RW-1:0] push_data,
    input  logic            pop,
    output logic            not_empty,
    output logic            room,
    output logic [RW-1:0]   head
);

    logic [RW-1:0] mem_reg [4];
    logic [1:0]    wr_reg, wr_next;
    logic [1:0]    rd_reg, rd_next;
    logic [2:0]    cnt_reg, cnt_next;
    logic          do_pop;

    assign not_empty = cnt_reg != 3'd0;
    assign room      = cnt_reg <= 3'd1;
    assign head      = mem_reg[rd_reg];
    assign do_pop    = pop && not_empty;

    always_comb begin
        wr_next  = wr_reg + push_count;
        rd_next  = rd_reg + {1'b0, do_pop};
        cnt_next = cnt_reg + {1'b0, push_count} - {2'b0, do_pop};
    end

    always_ff @(posedge aclk) begin
        if (push_count > 2'd0) mem_reg[wr_reg]        <= push_data[RW-1:0];
        if (push_count > 2'd1) mem_reg[wr_reg + 2'd1] <= push_data[2*RW-1:RW];
        if (push_count > 2'd2) mem_reg[wr_reg + 2'd2] <= push_data[3*RW-1:2*RW];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

FILE: rtl/core/source_tokenizer.sv
// Top level of the streaming source tokenizer.
//
//  Channel  Direction  Payload
//  s_       in         tdata: source_byte; tlast: end_of_source
//  m_       out        tdata: token fields; tlast: last token of the request
//
// One source byte is accepted per cycle while s_tready is high; its tokens are
// written to a four-entry queue in the same cycle and leave one per cycle
// while m_tready is high. s_tready is high while the queue holds at most one
// token. Reset is synchronous and returns position to row 1, column 1,
// offset 0.
module source_tokenizer #(
    parameter int OFFSET_BITS     = stok_pkg::OFFSET_BITS_DEF,
    parameter int POSITION_BITS   = stok_pkg::POSITION_BITS_DEF,
    parameter int KEYWORD_MAX_LEN = stok_pkg::KEYWORD_MAX_LEN_DEF,
    localparam int FW = stok_pkg::KIND_BITS + OFFSET_BITS + 2 * POSITION_BITS
                        + stok_pkg::LEN_BITS,
    localparam int DW = ((FW + 7) / 8) * 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,   // source_byte
    input  logic          s_tlast,   // end_of_source
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [DW-1:0] m_tdata,   // token_kind, start_offset, start_row,
                                     // start_column, token_length
    output logic          m_tlast    // last_of_run
);

    localparam int RW = FW + 1;

    logic            take;
    logic [1:0]      push_count;
    logic [3*RW-1:0] push_data;
    logic [RW-1:0]   head;

    assign take = s_tvalid && s_tready;

    stok_scan #(
        .OFFSET_BITS(OFFSET_BITS),
        .POSITION_BITS(POSITION_BITS),
        .KEYWORD_MAX_LEN(KEYWORD_MAX_LEN),
        .RW(RW)
    ) u_scan (
        .aclk(aclk),
        .aresetn(aresetn),
        .take(take),
        .source_byte(s_tdata),
        .end_of_source(s_tlast),
        .push_count(push_count),
        .push_data(push_data)
    );

    stok_fifo #(
        .RW(RW)
    ) u_fifo (
        .aclk(aclk),
        .aresetn(aresetn),
        .push_count(push_count),
        .push_data(push_data),
        .pop(m_tready),
        .not_empty(m_tvalid),
        .room(s_tready),
        .head(head)
    );

    assign m_tdata = DW'(head[FW-1:0]);
    assign m_tlast = head[RW-1];

endmodule

FILE: tb/source_tokenizer_tb.sv
// Self-checking testbench for the source tokenizer: byte stream in, predicted tokens compared out.
module source_tokenizer_tb;

    localparam int DW = 80;

    typedef enum logic [5:0] {
        K_PLUS, K_PLUS_EQ, K_MINUS, K_MINUS_EQ, K_ARROW, K_STAR, K_STAR_EQ, K_SLASH,
        K_SLASH_EQ, K_SEMI, K_COLON, K_DCOLON, K_COMMA, K_LPAREN, K_PARENS, K_RPAREN,
        K_LBRACE, K_RBRACE, K_LBRACK, K_RBRACK, K_DOT, K_DDOT, K_BANG, K_NOT_EQ,
        K_PERCENT, K_UNDER, K_BAR, K_ASSIGN, K_EQ, K_STRING, K_INT, K_BOOL,
        K_IF, K_ELSE, K_ELIF, K_WHILE, K_FOR, K_THEN, K_BREAK, K_TYPE,
        K_IDENT, K_END, K_ERROR, K_NONE = 6'd63
    } tok_kind_e;

    typedef enum logic [2:0] {
        LX_IDLE, LX_OP, LX_WORD, LX_INT, LX_FRAC, LX_STR
    } lex_mode_e;

    typedef struct {
        logic [7:0] ch;
        logic       eos;
    } src_req_t;

    typedef struct {
        tok_kind_e   kind;
        logic [23:0] off;
        logic [15:0] row;
        logic [15:0] col;
        logic [15:0] len;
        logic        last;
    } token_t;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [7:0]    s_tdata = 8'd0;
    logic          s_tlast = 1'b0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [DW-1:0] m_tdata;
    logic          m_tlast;

    source_tokenizer dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    src_req_t  source_q[$];
    token_t    token_q[$];
    int        fail_count = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    logic      rx_hold_req = 1'b0;
    logic      rx_hold_done = 1'b0;
    int        rx_hold_cnt = 0;
    logic      took;

    // Predictor state.
    lex_mode_e   lx_mode;
    logic [7:0]  lx_pend;
    logic [23:0] lx_off;
    logic [15:0] lx_row, lx_col;
    logic [23:0] tk_off;
    logic [15:0] tk_row, tk_col, tk_len;
    logic [39:0] word_buf;
    logic        lx_halted;
    int          step_n;

    function automatic logic [15:0] sat_add(input logic [15:0] v, input logic [15:0] a);
        logic [16:0] s;
        s = {1'b0, v} + {1'b0, a};
        return s[16] ? 16'hffff : s[15:0];
    endfunction

    function automatic tok_kind_e op_single(input logic [7:0] c);
        case (c)
            "+": return K_PLUS;    "-": return K_MINUS;   "*": return K_STAR;
            "/": return K_SLASH;   ";": return K_SEMI;    ":": return K_COLON;
            ",": return K_COMMA;   "(": return K_LPAREN;  ")": return K_RPAREN;
            "{": return K_LBRACE;  "}": return K_RBRACE;  "[": return K_LBRACK;
            "]": return K_RBRACK;  ".": return K_DOT;     "!": return K_BANG;
            "%": return K_PERCENT; "_": return K_UNDER;   "|": return K_BAR;
            "=": return K_ASSIGN;
            default: return K_NONE;
        endcase
    endfunction

    function automatic tok_kind_e op_pair(input logic [7:0] a, input logic [7:0] b);
        if (b == "=") begin
            case (a)
                "+": return K_PLUS_EQ;  "-": return K_MINUS_EQ; "*": return K_STAR_EQ;
                "/": return K_SLASH_EQ; "!": return K_NOT_EQ;   "=": return K_EQ;
                default: return K_NONE;
            endcase
        end
        if (a == "-" && b == ">") return K_ARROW;
        if (a == ":" && b == ":") return K_DCOLON;
        if (a == "(" && b == ")") return K_PARENS;
        if (a == "." && b == ".") return K_DDOT;
        return K_NONE;
    endfunction

    function automatic logic can_pair(input logic [7:0] c);
        return c == "+" || c == "-" || c == "*" || c == "/" || c == ":" ||
               c == "(" || c == "." || c == "!" || c == "=";
    endfunction

    function automatic logic letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic known_byte(input logic [7:0] c);
        return letter(c) || digit(c) || op_single(c) != K_NONE || c == " " ||
               c == "\t" || c == "\r" || c == "\n" || c == "\"";
    endfunction

    function automatic tok_kind_e word_kind(input logic [39:0] w, input logic [15:0] n);
        if (n > 16'd5) return K_IDENT;
        case (w)
            40'("false"), 40'("true"): return K_BOOL;
            40'("if"):    return K_IF;
            40'("else"):  return K_ELSE;
            40'("elif"):  return K_ELIF;
            40'("while"): return K_WHILE;
            40'("for"):   return K_FOR;
            40'("then"):  return K_THEN;
            40'("break"): return K_BREAK;
            40'("type"):  return K_TYPE;
            default:      return K_IDENT;
        endcase
    endfunction

    task put_token(input tok_kind_e k, input logic [23:0] o, input logic [15:0] r,
                   input logic [15:0] c, input logic [15:0] n);
        token_t t;
        if (step_n < 3) begin
            t.kind = k; t.off = o; t.row = r; t.col = c; t.len = n; t.last = 1'b0;
            token_q.push_back(t);
            step_n++;
        end
    endtask

    task put_pending(input tok_kind_e k);
        put_token(k, tk_off, tk_row, tk_col, tk_len);
    endtask

    task open_token();
        tk_off = lx_off; tk_row = lx_row; tk_col = lx_col; tk_len = 16'd0; word_buf = '0;
    endtask

    task advance();
        lx_off = lx_off + 24'd1;
        lx_col = sat_add(lx_col, 16'd1);
    endtask

    task grow();
        if (tk_len != 16'hffff) tk_len = tk_len + 16'd1;
    endtask

    task flush_pending();
        case (lx_mode)
            LX_OP:            put_pending(op_single(lx_pend));
            LX_WORD:          put_pending(word_kind(word_buf, tk_len));
            LX_INT, LX_FRAC:  put_pending(K_INT);
            LX_STR:           put_pending(K_STRING);
            default: ;
        endcase
        lx_mode = LX_IDLE;
    endtask

    task scan_byte(input logic [7:0] c);
        tok_kind_e k;
        case (lx_mode)
            LX_OP: begin
                k = op_pair(lx_pend, c);
                if (k != K_NONE) begin
                    tk_len = 16'd2;
                    put_pending(k);
                    advance();
                    lx_mode = LX_IDLE;
                    return;
                end
                flush_pending();
            end
            LX_WORD: begin
                if (letter(c)) begin
                    if (tk_len < 16'd5) word_buf = {word_buf[31:0], c};
                    grow();
                    advance();
                    return;
                end
                flush_pending();
            end
            LX_INT: begin
                if (digit(c) || c == ".") begin
                    if (c == ".") lx_mode = LX_FRAC;
                    grow();
                    advance();
                    return;
                end
                flush_pending();
            end
            LX_FRAC: begin
                if (digit(c)) begin
                    grow();
                    advance();
                    return;
                end
                flush_pending();
            end
            LX_STR: begin
                if (c == "\"") begin
                    put_pending(K_STRING);
                    lx_mode = LX_IDLE;
                end else begin
                    grow();
                end
                advance();
                return;
            end
            default: lx_mode = LX_IDLE;
        endcase
        if (c == "\r" || c == "\n") begin
            lx_row = sat_add(lx_row, 16'd1);
            lx_col = 16'd1;
            lx_off = lx_off + 24'd1;
        end else if (c == "\t") begin
            lx_col = sat_add(lx_col, 16'd4);
            lx_off = lx_off + 24'd1;
        end else if (c == " ") begin
            advance();
        end else if (c == "\"") begin
            open_token();
            advance();
            lx_mode = LX_STR;
        end else if (digit(c)) begin
            open_token();
            tk_len = 16'd1;
            advance();
            lx_mode = LX_INT;
        end else if (letter(c)) begin
            open_token();
            tk_len = 16'd1;
            word_buf = {32'd0, c};
            advance();
            lx_mode = LX_WORD;
        end else if (can_pair(c)) begin
            open_token();
            tk_len = 16'd1;
            lx_pend = c;
            advance();
            lx_mode = LX_OP;
        end else if (op_single(c) != K_NONE) begin
            open_token();
            tk_len = 16'd1;
            put_pending(op_single(c));
            advance();
        end else begin
            put_token(K_ERROR, lx_off, lx_row, lx_col, 16'd1);
            lx_halted = 1'b1;
        end
    endtask

    task predict_tokens(input logic [7:0] c, input logic eos);
        token_t t;
        step_n = 0;
        if (lx_halted) return;
        if (c != 8'd0) scan_byte(c);
        if (!lx_halted && (c == 8'd0 || eos)) begin
            flush_pending();
            put_token(K_END, lx_off, lx_row, lx_col, 16'd0);
            lx_halted = 1'b1;
        end
        if (step_n > 0) begin
            t = token_q[$];
            t.last = 1'b1;
            token_q[$] = t;
        end
    endtask

    // Checks finished tokens, then predicts from the request taken at this edge.
    always @(posedge aclk) begin
        token_t t;
        if (!aresetn) begin
            lx_mode = LX_IDLE; lx_pend = 8'd0; lx_off = 24'd0; lx_row = 16'd1;
            lx_col = 16'd1; tk_off = 24'd0; tk_row = 16'd1; tk_col = 16'd1;
            tk_len = 16'd0; word_buf = '0; lx_halted = 1'b0;
            took = 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (token_q.size() == 0) begin
                    $error("unexpected token kind %0d", m_tdata[5:0]);
                    fail_count++;
                end else begin
                    t = token_q.pop_front();
                    if (m_tdata[5:0] !== t.kind) begin
                        $error("token_kind expected %0d actual %0d", t.kind, m_tdata[5:0]);
                        fail_count++;
                    end
                    if (m_tdata[29:6] !== t.off) begin
                        $error("start_offset expected %0d actual %0d", t.off, m_tdata[29:6]);
                        fail_count++;
                    end
                    if (m_tdata[45:30] !== t.row) begin
                        $error("start_row expected %0d actual %0d", t.row, m_tdata[45:30]);
                        fail_count++;
                    end
                    if (m_tdata[61:46] !== t.col) begin
                        $error("start_column expected %0d actual %0d", t.col, m_tdata[61:46]);
                        fail_count++;
                    end
                    if (m_tdata[77:62] !== t.len) begin
                        $error("token_length expected %0d actual %0d", t.len, m_tdata[77:62]);
                        fail_count++;
                    end
                    if (m_tlast !== t.last) begin
                        $error("last_of_run expected %0d actual %0d", t.last, m_tlast);
                        fail_count++;
                    end
                end
            end
            took = s_tvalid && s_tready;
            if (took) predict_tokens(s_tdata, s_tlast);
        end
    end

    always @(negedge aclk) begin
        src_req_t r;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || took) begin
            if (source_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                r = source_q.pop_front();
                s_tdata  <= r.ch;
                s_tlast  <= r.eos;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (rx_hold_req && !rx_hold_done) begin
            m_tready <= 1'b0;
            rx_hold_cnt <= rx_hold_cnt + 1;
            if (rx_hold_cnt == 300) rx_hold_done <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task push_byte(input logic [7:0] c, input logic eos);
        src_req_t r;
        r.ch = c;
        r.eos = eos;
        source_q.push_back(r);
    endtask

    task push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i], 1'b0);
    endtask

    task push_random_token();
        string words[10];
        string ops;
        string pairs;
        string blanks;
        int n;
        logic [7:0] c;
        words = '{"false", "true", "if", "else", "elif", "while", "for", "then",
                  "break", "type"};
        ops = "+-*/;:,(){}[].!%_|=";
        pairs = "=:).";
        blanks = " \t\r\n";
        case ($urandom_range(9))
            0: begin
                push_text(words[$urandom_range(9)]);
                if ($urandom_range(3) == 0) push_byte(8'("a" + $urandom_range(25)), 1'b0);
            end
            1: begin
                n = $urandom_range(1, 8);
                repeat (n) begin
                    c = 8'("a" + $urandom_range(25));
                    push_byte($urandom_range(1) ? c : c - 8'h20, 1'b0);
                end
            end
            2: begin
                n = $urandom_range(1, 4);
                repeat (n) push_byte(8'("0" + $urandom_range(9)), 1'b0);
                if ($urandom_range(1)) begin
                    push_byte(".", 1'b0);
                    n = $urandom_range(3);
                    repeat (n) push_byte(8'("0" + $urandom_range(9)), 1'b0);
                    if ($urandom_range(3) == 0) push_byte(".", 1'b0);
                end
            end
            3: begin
                push_byte("\"", 1'b0);
                n = $urandom_range(6);
                repeat (n) begin
                    do c = 8'($urandom_range(1, 255)); while (c == "\"");
                    push_byte(c, 1'b0);
                end
                push_byte("\"", 1'b0);
            end
            4, 5, 6: begin
                c = ops[$urandom_range(ops.len() - 1)];
                push_byte(c, 1'b0);
                if ($urandom_range(1)) begin
                    if (c == "-" && $urandom_range(1)) push_byte(">", 1'b0);
                    else push_byte(pairs[$urandom_range(3)], 1'b0);
                end
            end
            default: push_byte(blanks[$urandom_range(3)], 1'b0);
        endcase
        if ($urandom_range(2) != 0) push_byte(" ", 1'b0);
    endtask

    task wait_drained();
        while (source_q.size() != 0 || s_tvalid || token_q.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    initial begin
        #(12 * 3000000);
        $display("source_tokenizer_tb failed");
        $finish;
    end

    initial begin
        logic [7:0] c;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        send_idle_pct = 17;
        recv_idle_pct = 75;
        push_text("+=-=->*=/=!===::()..;,{}[]%_|+ ");
        push_text("if else elif while for then break type true false xYz ");
        push_text("12.5.7 \"a\xff\x80\" \t\r\n");
        repeat (25) push_random_token();
        wait_drained();

        send_idle_pct = 75;
        recv_idle_pct = 17;
        repeat (25) push_random_token();
        wait_drained();

        // The receiver stops while the sender keeps offering.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rx_hold_req = 1'b1;
        repeat (25) push_random_token();
        wait_drained();

        repeat (15) push_random_token();

        case ($urandom_range(2))
            0: push_byte(8'd0, 1'($urandom_range(1)));
            1: begin
                do c = 8'($urandom_range(1, 255)); while (known_byte(c));
                push_byte(c, 1'($urandom_range(1)));
            end
            default: begin
                push_random_token();
                push_byte(8'("a" + $urandom_range(25)), 1'b1);
            end
        endcase
        repeat (3) push_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
        wait_drained();
        repeat (20) @(posedge aclk);

        if (fail_count == 0) begin
            $display("source_tokenizer_tb passed");
        end else begin
            $display("source_tokenizer_tb failed");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/core/stok_pkg.sv
rtl/core/stok_scan.sv
rtl/core/stok_fifo.sv
rtl/core/source_tokenizer.sv
tb/source_tokenizer_tb.sv
